/* hw/rtl/pss_pkg.sv */
// pss_pkg: shared types and constants of the padded size selector.
// Payload structs, status and source codes, controller/datapath interface.
// No dependencies.
`timescale 1ns / 1ps

package pss_pkg;

  localparam int SIZE_W    = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [SIZE_W-1:0] SMALL_LIMIT = 24'd10;

  localparam logic [SIZE_W-1:0] MULT_LO_RST  = 24'd10;
  localparam logic [SIZE_W-1:0] MULT_HI_RST  = 24'd2;
  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 24'd65536;

  localparam logic [CFG_IDX_W-1:0] CFG_MULT_LO  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_HI  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIZE = 2'd2;

  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pss_status_t;

  // where the result size comes from
  typedef enum logic [1:0] {
    SRC_REQ = 2'd0,
    SRC_HIT = 2'd1,
    SRC_KEY = 2'd2
  } pss_src_t;

  typedef struct packed {
    logic              req_type;
    logic [SIZE_W-1:0] size_value;
  } pss_in_t;

  typedef struct packed {
    logic [SIZE_W-1:0] chosen_size;
    logic              list_changed;
    pss_status_t       status;
  } pss_out_t;

  typedef struct packed {
    logic        load_in;
    logic        scan_start;
    logic        strict;
    logic        scan;
    logic        mul;
    logic        pad;
    logic        shift_start;
    logic        shift;
    logic        put;
    logic        res_load;
    pss_status_t res_status;
    pss_src_t    res_src;
    logic        res_changed;
  } pss_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic is_load;
    logic scan_done;
    logic shift_done;
    logic hit;
    logic eq;
    logic last_eq;
    logic full;
  } pss_stat_t;

endpackage

/* hw/rtl/pss_ctrl.sv */
// pss_ctrl: sequencing state machine of the padded size selector.
// Drives pss_cmd_t to the datapath, reads pss_stat_t back. Uses pss_pkg.
`timescale 1ns / 1ps

module pss_ctrl import pss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pss_stat_t stat,
  output pss_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN_Q, S_Q_DEC, S_MUL, S_PAD, S_Q_INS,
    S_SCAN_L, S_L_DEC, S_SHIFT, S_PUT, S_RESP
  } state_t;

  state_t      state_r;
  logic        out_valid_r;
  pss_status_t res_status_r;
  pss_src_t    res_src_r;
  logic        res_changed_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd             = '0;
    cmd.res_status  = res_status_r;
    cmd.res_src     = res_src_r;
    cmd.res_changed = res_changed_r;
    unique case (state_r)
      S_IDLE:   cmd.load_in = in_valid;
      S_CHECK: begin
        if (!stat.range_bad) begin
          cmd.scan_start = 1'b1;
          cmd.strict     = !stat.is_load;  // query looks for first entry above
        end
      end
      S_SCAN_Q,
      S_SCAN_L: cmd.scan = 1'b1;
      S_MUL:    cmd.mul = 1'b1;
      S_PAD:    cmd.pad = 1'b1;
      S_L_DEC:  cmd.shift_start = !(stat.hit && stat.eq) && !stat.full;
      S_SHIFT:  cmd.shift = 1'b1;
      S_PUT:    cmd.put = 1'b1;
      S_RESP:   cmd.res_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      res_status_r  <= ST_OK;
      res_src_r     <= SRC_REQ;
      res_changed_r <= 1'b0;
    end else begin
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (stat.range_bad) begin
            res_status_r  <= ST_RANGE;
            res_src_r     <= SRC_REQ;
            res_changed_r <= 1'b0;
            state_r       <= S_RESP;
          end else if (stat.is_load) begin
            state_r <= S_SCAN_L;
          end else begin
            state_r <= S_SCAN_Q;
          end
        end
        S_SCAN_Q: begin
          if (stat.scan_done) state_r <= S_Q_DEC;
        end
        S_Q_DEC: begin
          if (stat.hit) begin
            res_status_r  <= ST_OK;
            res_src_r     <= SRC_HIT;
            res_changed_r <= 1'b0;
            state_r       <= S_RESP;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_PAD;
        S_PAD: state_r <= S_Q_INS;
        S_Q_INS: begin
          // no entry above the request: padded size goes at the tail
          if (stat.last_eq) begin
            res_status_r  <= ST_OK;
            res_src_r     <= SRC_KEY;
            res_changed_r <= 1'b0;
            state_r       <= S_RESP;
          end else if (stat.full) begin
            res_status_r  <= ST_FULL;
            res_src_r     <= SRC_REQ;
            res_changed_r <= 1'b0;
            state_r       <= S_RESP;
          end else begin
            state_r <= S_PUT;
          end
        end
        S_SCAN_L: begin
          if (stat.scan_done) state_r <= S_L_DEC;
        end
        S_L_DEC: begin
          if (stat.hit && stat.eq) begin
            res_status_r  <= ST_OK;
            res_src_r     <= SRC_KEY;
            res_changed_r <= 1'b0;
            state_r       <= S_RESP;
          end else if (stat.full) begin
            res_status_r  <= ST_FULL;
            res_src_r     <= SRC_REQ;
            res_changed_r <= 1'b0;
            state_r       <= S_RESP;
          end else begin
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (stat.shift_done) state_r <= S_PUT;
        end
        S_PUT: begin
          res_status_r  <= ST_OK;
          res_src_r     <= SRC_KEY;
          res_changed_r <= 1'b1;
          state_r       <= S_RESP;
        end
        S_RESP: begin
          if (cmd.res_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/pss_datapath.sv */
// pss_datapath: size table memory, scan and shift counters, padding multiply,
// configuration registers and result register. Uses pss_pkg.
`timescale 1ns / 1ps

module pss_datapath import pss_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  input  pss_in_t              in_data,
  input  pss_cmd_t             cmd,
  output pss_stat_t            stat,
  output pss_out_t             out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [SIZE_W-1:0] mem [TABLE_DEPTH];
  logic [SIZE_W-1:0] rdata_r;

  logic [SIZE_W-1:0] mult_lo_r, mult_hi_r, max_size_r;

  logic              req_type_r;
  logic [SIZE_W-1:0] req_size_r;
  logic [SIZE_W-1:0] key_r;
  logic              strict_r;
  logic [CW-1:0]     idx_r;
  logic              pend_r;
  logic [CW-1:0]     pos_r;
  logic              hit_r;
  logic [SIZE_W-1:0] hitval_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     rem_r;
  logic [AW-1:0]     sa_r;
  logic [AW-1:0]     wa_r;
  logic [2*SIZE_W-1:0] prod_r;
  pss_out_t          out_r;

  logic              ge;
  logic              stop_hit, stop_end;
  logic [SIZE_W-1:0] fac_sel, fac_eff;
  logic [2*SIZE_W-1:0] prod_nxt;
  logic [SIZE_W-1:0] pad_nxt;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [SIZE_W-1:0] mem_wd;

  // scan compare; previous cycle's read is for address idx_r-1
  assign ge       = strict_r ? (rdata_r > key_r) : (rdata_r >= key_r);
  assign stop_hit = pend_r && ge;
  assign stop_end = !stop_hit && (idx_r >= count_r);

  // zero factor acts as one
  assign fac_sel  = (req_size_r < SMALL_LIMIT) ? mult_lo_r : mult_hi_r;
  assign fac_eff  = (fac_sel == '0) ? SIZE_W'(1) : fac_sel;
  assign prod_nxt = (2*SIZE_W)'(req_size_r) * (2*SIZE_W)'(fac_eff);
  assign pad_nxt  = (prod_r > {{SIZE_W{1'b0}}, max_size_r}) ? req_size_r
                                                             : prod_r[SIZE_W-1:0];

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wd = key_r;
    if (cmd.scan && !stop_hit && !stop_end) begin
      mem_re = 1'b1;
      mem_ra = idx_r[AW-1:0];
    end
    if (cmd.shift && (rem_r != '0)) begin
      mem_re = 1'b1;
      mem_ra = sa_r;
    end
    if (cmd.shift && pend_r) begin
      mem_we = 1'b1;
      mem_wa = wa_r;
      mem_wd = rdata_r;
    end
    if (cmd.put) begin
      mem_we = 1'b1;
      mem_wa = pos_r[AW-1:0];
      mem_wd = key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_lo_r  <= MULT_LO_RST;
      mult_hi_r  <= MULT_HI_RST;
      max_size_r <= MAX_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MULT_LO:  mult_lo_r  <= cfg_data;
        CFG_MULT_HI:  mult_hi_r  <= cfg_data;
        CFG_MAX_SIZE: max_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        req_type_r <= in_data.req_type;
        req_size_r <= in_data.size_value;
        key_r      <= in_data.size_value;
      end
      if (cmd.scan_start) begin
        idx_r    <= '0;
        pend_r   <= 1'b0;
        strict_r <= cmd.strict;
      end
      if (cmd.scan) begin
        if (stop_hit) begin
          pos_r    <= idx_r - 1'b1;
          hit_r    <= 1'b1;
          hitval_r <= rdata_r;
          pend_r   <= 1'b0;
        end else if (stop_end) begin
          // rdata_r holds the last entry here when the table is not empty
          pos_r    <= count_r;
          hit_r    <= 1'b0;
          hitval_r <= rdata_r;
          pend_r   <= 1'b0;
        end else begin
          idx_r  <= idx_r + 1'b1;
          pend_r <= 1'b1;
        end
      end
      if (cmd.mul) prod_r <= prod_nxt;
      if (cmd.pad) key_r <= pad_nxt;
      if (cmd.shift_start) begin
        rem_r  <= count_r - pos_r;
        sa_r   <= AW'(count_r - 1'b1);
        pend_r <= 1'b0;
      end
      if (cmd.shift) begin
        // move entries up one slot, top down
        if (rem_r != '0) begin
          sa_r   <= sa_r - 1'b1;
          rem_r  <= rem_r - 1'b1;
          wa_r   <= sa_r + 1'b1;
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (cmd.put) count_r <= count_r + 1'b1;
      if (cmd.res_load) begin
        unique case (cmd.res_src)
          SRC_HIT: out_r.chosen_size <= hitval_r;
          SRC_KEY: out_r.chosen_size <= key_r;
          default: out_r.chosen_size <= req_size_r;
        endcase
        out_r.list_changed <= cmd.res_changed;
        out_r.status       <= cmd.res_status;
      end
    end
  end

  assign stat.range_bad  = (req_size_r == '0) || (req_size_r > max_size_r);
  assign stat.is_load    = (req_type_r == REQ_LOAD);
  assign stat.scan_done  = stop_hit || stop_end;
  assign stat.shift_done = (rem_r == '0) && !pend_r;
  assign stat.hit        = hit_r;
  assign stat.eq         = (hitval_r == key_r);
  assign stat.last_eq    = (count_r != '0) && (hitval_r == key_r);
  assign stat.full       = (count_r == CW'(TABLE_DEPTH));

  assign out_data = out_r;

endmodule

/* hw/rtl/padded_size_selector.sv */
// padded_size_selector: top level, sorted padded-size table with lookup/insert.
// Instantiates pss_ctrl and pss_datapath; uses pss_pkg.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | in_data  (pss_in_t: req_type, size_value)
//  out      | out_valid / out_ready | out_data (pss_out_t: chosen, changed, status)
//  cfg      | cfg_valid / cfg_ready | cfg_index (register), cfg_data (value)
//
// One item at a time. A transfer on in starts a linear scan of the table
// memory, one entry per cycle through its registered read port.
// With out ready, the result shows in the same cycle as in reopens. A query
// hit returns the first entry above the request; a query miss multiplies,
// pads and puts the padded size at the tail unless the last entry holds it;
// a load of a new size scans to the slot and shifts the entries above it one
// per cycle; an out-of-range item is answered without a scan.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
// A stall on out holds the item in its result state until out is free;
// the result register frees in once the result is loaded. cfg is always ready.
`timescale 1ns / 1ps

module padded_size_selector import pss_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pss_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pss_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  pss_cmd_t  cmd;
  pss_stat_t stat;

  // register writes are never held off
  assign cfg_ready = 1'b1;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pss_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/pss_checker.sv */
// pss_checker: port-level assertions for padded_size_selector, with bind.
// Uses pss_pkg.
`timescale 1ns / 1ps

module pss_checker import pss_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input pss_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input pss_out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // waiting input holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input changed while waiting");

  // an insertion is only reported on success
  a_changed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.list_changed |-> out_data.status == ST_OK)
    else $error("list_changed with error status");

  // size zero is always out of range
  a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.chosen_size == '0) |-> out_data.status == ST_RANGE)
    else $error("zero size not flagged");

  // one item in flight: input closes after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second input taken while busy");

endmodule

bind padded_size_selector pss_checker u_pss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
